// ===== rtl/bca_pkg.sv =====
// Package with the shared widths, codes, state type and control structs of the chunk allocator.
package bca_pkg;

  localparam int POOL_CHUNKS_DEF = 16;
  localparam int CHUNK_BYTES_DEF = 32;

  localparam int REQ_W    = 1;
  localparam int SIZE_W   = 5;
  localparam int START_W  = 4;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 9;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 1'b0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic do_free;
    logic do_alloc;
    logic step;
    logic res_bad;
    logic res_full;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_size;
    logic slot_over;
    logic slot_free;
  } sts_t;

endpackage

// ===== rtl/bca_ctrl.sv =====
// Controller state machine that sequences one request through decode and the slot scan.
module bca_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  input  bca_pkg::sts_t sts,
  output bca_pkg::cmd_t cmd
);

  bca_pkg::state_t state_r;
  bca_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bca_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      bca_pkg::S_IDLE, bca_pkg::S_DONE: begin
        out_valid = (state_r == bca_pkg::S_DONE);
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = bca_pkg::S_EXEC;
        end else begin
          state_nxt = bca_pkg::S_IDLE;
        end
      end
      bca_pkg::S_EXEC: begin
        busy = 1'b1;
        if (sts.is_free) begin
          cmd.do_free = 1'b1;
          state_nxt   = bca_pkg::S_DONE;
        end else if (sts.bad_size) begin
          cmd.res_bad = 1'b1;
          state_nxt   = bca_pkg::S_DONE;
        end else begin
          state_nxt = bca_pkg::S_SCAN;
        end
      end
      bca_pkg::S_SCAN: begin
        busy = 1'b1;
        if (sts.slot_over) begin
          cmd.res_full = 1'b1;
          state_nxt    = bca_pkg::S_DONE;
        end else if (sts.slot_free) begin
          cmd.do_alloc = 1'b1;
          state_nxt    = bca_pkg::S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = bca_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bca_datapath.sv =====
// Datapath holding the used bitmap, the request, the slot pointer and the result registers.
module bca_datapath #(
  parameter int POOL_CHUNKS = bca_pkg::POOL_CHUNKS_DEF,
  parameter int CHUNK_BYTES = bca_pkg::CHUNK_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bca_pkg::cmd_t                  cmd,
  output bca_pkg::sts_t                  sts,
  input  logic [bca_pkg::REQ_W-1:0]      in_req_type,
  input  logic [bca_pkg::SIZE_W-1:0]     in_alloc_chunks,
  input  logic [bca_pkg::START_W-1:0]    in_free_start,
  input  logic [bca_pkg::SIZE_W-1:0]     in_free_chunks,
  output logic [bca_pkg::STATUS_W-1:0]   out_status,
  output logic [bca_pkg::START_W-1:0]    out_start_chunk,
  output logic [bca_pkg::SIZE_W-1:0]     out_size_chunks,
  output logic [bca_pkg::OFFSET_W-1:0]   out_byte_offset
);

  localparam int IW = $clog2(POOL_CHUNKS) + 1;
  localparam int SW = ((IW > bca_pkg::SIZE_W) ? IW : bca_pkg::SIZE_W) + 1;
  localparam logic [SW-1:0] POOL_SW = SW'(POOL_CHUNKS);
  localparam logic [bca_pkg::OFFSET_W-1:0] CB_LOW =
    bca_pkg::OFFSET_W'(CHUNK_BYTES % (1 << bca_pkg::OFFSET_W));

  logic [bca_pkg::REQ_W-1:0]    req_r;
  logic [bca_pkg::SIZE_W-1:0]   n_r;
  logic [bca_pkg::START_W-1:0]  fs_r;
  logic [bca_pkg::SIZE_W-1:0]   fn_r;
  logic [SW-1:0]                i_r;
  logic [POOL_CHUNKS-1:0]       used_r;
  logic [POOL_CHUNKS-1:0]       used_nxt;
  logic [bca_pkg::STATUS_W-1:0] status_r;
  logic [bca_pkg::START_W-1:0]  start_r;
  logic [bca_pkg::SIZE_W-1:0]   size_r;
  logic [bca_pkg::OFFSET_W-1:0] offset_r;

  logic [SW-1:0]                n_ext;
  logic [SW-1:0]                slot_end;
  logic [SW-1:0]                fs_ext;
  logic [SW-1:0]                free_end;
  logic [POOL_CHUNKS-1:0]       slot_mask;
  logic [POOL_CHUNKS-1:0]       free_mask;
  logic [bca_pkg::OFFSET_W-1:0] i_off;

  assign n_ext    = SW'(n_r);
  assign slot_end = i_r + n_ext;
  assign fs_ext   = SW'(fs_r);
  assign free_end = fs_ext + SW'(fn_r);
  assign i_off    = bca_pkg::OFFSET_W'(i_r);

  always_comb begin
    for (int k = 0; k < POOL_CHUNKS; k++) begin
      slot_mask[k] = (SW'(k) >= i_r) && (SW'(k) < slot_end);
      free_mask[k] = (SW'(k) >= fs_ext) && (SW'(k) < free_end) && (fs_ext < POOL_SW);
    end
  end

  assign sts.is_free   = (req_r == bca_pkg::REQ_FREE);
  assign sts.bad_size  = (n_r == '0) || (n_ext > POOL_SW);
  assign sts.slot_over = (slot_end > POOL_SW);
  assign sts.slot_free = ((slot_mask & used_r) == '0);

  always_comb begin
    used_nxt = used_r;
    if (cmd.do_free) begin
      used_nxt = used_r & ~free_mask;
    end else if (cmd.do_alloc) begin
      used_nxt = used_r | slot_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req_type;
      n_r   <= in_alloc_chunks;
      fs_r  <= in_free_start;
      fn_r  <= in_free_chunks;
      i_r   <= '0;
    end else if (cmd.step) begin
      i_r <= slot_end;
    end
    if (cmd.do_free || cmd.res_bad || cmd.res_full) begin
      status_r <= cmd.do_free ? bca_pkg::ST_OK
                : (cmd.res_bad ? bca_pkg::ST_BAD : bca_pkg::ST_FULL);
      start_r  <= '0;
      size_r   <= '0;
      offset_r <= '0;
    end else if (cmd.do_alloc) begin
      status_r <= bca_pkg::ST_OK;
      start_r  <= bca_pkg::START_W'(i_r);
      size_r   <= n_r;
      offset_r <= i_off * CB_LOW;
    end
  end

  assign out_status      = status_r;
  assign out_start_chunk = start_r;
  assign out_size_chunks = size_r;
  assign out_byte_offset = offset_r;

endmodule

// ===== rtl/bitmap_chunk_allocator.sv =====
// Top level of the first-fit chunk allocator: controller plus bitmap datapath.
// A free or a rejected size goes from decode straight to done, where its result is shown.
// A successful allocate goes from decode into the slot scan, which checks aligned slots
// one per cycle, at most POOL_CHUNKS / size (rounded down), before it reaches done.
// A full pool checks every slot, then sees the scan run off the end and reports full.
// A new request may be accepted in the cycle its predecessor's result is shown.
// Reset clears the used bitmap to all free; results are never stalled.
module bitmap_chunk_allocator #(
  parameter int POOL_CHUNKS = bca_pkg::POOL_CHUNKS_DEF,
  parameter int CHUNK_BYTES = bca_pkg::CHUNK_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bca_pkg::REQ_W-1:0]      in_req_type,
  input  logic [bca_pkg::SIZE_W-1:0]     in_alloc_chunks,
  input  logic [bca_pkg::START_W-1:0]    in_free_start,
  input  logic [bca_pkg::SIZE_W-1:0]     in_free_chunks,
  output logic                           out_valid,
  output logic [bca_pkg::STATUS_W-1:0]   out_status,
  output logic [bca_pkg::START_W-1:0]    out_start_chunk,
  output logic [bca_pkg::SIZE_W-1:0]     out_size_chunks,
  output logic [bca_pkg::OFFSET_W-1:0]   out_byte_offset
);

  bca_pkg::cmd_t cmd;
  bca_pkg::sts_t sts;

  bca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  bca_datapath #(
    .POOL_CHUNKS (POOL_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_alloc_chunks (in_alloc_chunks),
    .in_free_start   (in_free_start),
    .in_free_chunks  (in_free_chunks),
    .out_status      (out_status),
    .out_start_chunk (out_start_chunk),
    .out_size_chunks (out_size_chunks),
    .out_byte_offset (out_byte_offset)
  );

endmodule

// ===== rtl/bca_checker.sv =====
// Port-level checker for the chunk allocator, bound to the top level.
module bca_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [bca_pkg::STATUS_W-1:0]   out_status,
  input logic [bca_pkg::START_W-1:0]    out_start_chunk,
  input logic [bca_pkg::SIZE_W-1:0]     out_size_chunks,
  input logic [bca_pkg::OFFSET_W-1:0]   out_byte_offset
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe lasted more than one cycle.");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("Accepted request did not make the block busy.");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("Block left busy without showing a result.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == bca_pkg::ST_FULL || out_status == bca_pkg::ST_BAD))
      |-> (out_start_chunk == '0 && out_size_chunks == '0 && out_byte_offset == '0))
    else $error("Failed request returned a non-zero block.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bca_pkg::ST_OK || out_status == bca_pkg::ST_FULL ||
                   out_status == bca_pkg::ST_BAD))
    else $error("Result carried an undefined status code.");

endmodule

bind bitmap_chunk_allocator bca_checker u_bca_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_start_chunk (out_start_chunk),
  .out_size_chunks (out_size_chunks),
  .out_byte_offset (out_byte_offset)
);
